@@ design/pcx_rle_pkg.sv @@
// ----------------------------------------------------------------------------
// PCX run-length decoder package
// Shared constants, header offsets, phase codes and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

  // Largest image the decoder accepts; xmax and ymax must stay below these.
  localparam int MAX_WIDTH  = 640;
  localparam int MAX_HEIGHT = 480;

  localparam int HEADER_BYTES = 128;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

  // Field widths of a pixel result.
  localparam int PIXEL_W  = 8;
  localparam int COLUMN_W = 10;
  localparam int LINE_W   = 9;
  localparam int COUNT_W  = 6;
  localparam int LIMIT_W  = 16;

  // The column counter holds xmax plus a whole run of 63 pixels.
  localparam int COL_CNT_W  = $clog2(MAX_WIDTH + 63);
  localparam int LINE_CNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Header byte offsets that are checked or captured.
  localparam logic [HDR_CNT_W-1:0] HDR_MANUFACTURER = HDR_CNT_W'(0);
  localparam logic [HDR_CNT_W-1:0] HDR_VERSION      = HDR_CNT_W'(1);
  localparam logic [HDR_CNT_W-1:0] HDR_ENCODING     = HDR_CNT_W'(2);
  localparam logic [HDR_CNT_W-1:0] HDR_BPP          = HDR_CNT_W'(3);
  localparam logic [HDR_CNT_W-1:0] HDR_XMAX_LO      = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] HDR_XMAX_HI      = HDR_CNT_W'(9);
  localparam logic [HDR_CNT_W-1:0] HDR_YMAX_LO      = HDR_CNT_W'(10);
  localparam logic [HDR_CNT_W-1:0] HDR_YMAX_HI      = HDR_CNT_W'(11);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST         = HDR_CNT_W'(HEADER_BYTES - 1);

  // Expected header contents.
  localparam logic [7:0] MANUFACTURER = 8'h0A;
  localparam logic [7:0] VERSION      = 8'd5;
  localparam logic [7:0] ENCODING     = 8'd1;
  localparam logic [7:0] PIXEL_DEPTH  = 8'd8;

  // A byte whose two top bits are set carries a run count.
  localparam logic [1:0] RUN_MARK = 2'b11;

  // Decoder phases.
  localparam logic [1:0] PH_HEADER     = 2'd0;
  localparam logic [1:0] PH_HEADER_BAD = 2'd1;
  localparam logic [1:0] PH_DATA       = 2'd2;
  localparam logic [1:0] PH_IDLE       = 2'd3;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic ready;  // input channel may take a transaction
    logic emit;   // load the output register with the head of the run
  } dp_cmd_t;

  typedef struct packed {
    logic take;       // input transaction completes this cycle
    logic produce;    // the byte being taken gives at least one result
    logic multi;      // the byte being taken gives more than one result
    logic slot_free;  // output register empty or being emptied
    logic run_last;   // the stored run has one result left
  } dp_stat_t;

endpackage

@@ design/pcx_rle_if.sv @@
// ----------------------------------------------------------------------------
// PCX run-length decoder channels
// Byte input channel and pixel result channel, both valid/ready.
// ----------------------------------------------------------------------------
interface pcx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface pcx_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel;
  logic [9:0] column;
  logic [8:0] line;
  logic       run_end;
  logic       image_end;

  modport source (output valid, output kind, output pixel, output column, output line,
                  output run_end, output image_end, input ready);
  modport sink (input valid, input kind, input pixel, input column, input line,
                input run_end, input image_end, output ready);
endinterface

@@ design/pcx_rle_ctrl.sv @@
// ----------------------------------------------------------------------------
// PCX run-length decoder controller
// Sequences input transactions and the emission of run pixels, one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module pcx_rle_ctrl
  import pcx_rle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic S_READY = 1'b0;
  localparam logic S_RUN   = 1'b1;

  logic state;
  logic state_next;
  logic in_ready;
  logic emit;

  assign in_ready = (state == S_READY);
  assign cmd      = '{ready: in_ready, emit: emit};

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (state)
      S_READY: begin
        if (stat.take && stat.produce) begin
          // The first result goes straight out when the output register allows.
          emit = stat.slot_free;
          if (!stat.slot_free || stat.multi) begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        emit = stat.slot_free;
        if (stat.slot_free && stat.run_last) begin
          state_next = S_READY;
        end
      end
      default: begin
        state_next = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READY;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/pcx_rle_dp.sv @@
// ----------------------------------------------------------------------------
// PCX run-length decoder datapath
// Header checks, run-length decoding, position counters, the run register
// and the output register.
// ----------------------------------------------------------------------------
module pcx_rle_dp
  import pcx_rle_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  pcx_byte_if.sink        bytes,
  pcx_pix_if.source       pixels,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat
);

  // Decoder state.
  logic [1:0]            phase;
  logic [HDR_CNT_W-1:0]  header_count;
  logic [LIMIT_W-1:0]    width_limit;
  logic [LIMIT_W-1:0]    height_limit;
  logic                  awaiting_value;
  logic [COUNT_W-1:0]    pending_count;
  logic [COL_CNT_W-1:0]  cur_column;
  logic [LINE_CNT_W-1:0] cur_line;

  logic [1:0]            phase_next;
  logic [HDR_CNT_W-1:0]  header_count_next;
  logic [LIMIT_W-1:0]    width_limit_next;
  logic [LIMIT_W-1:0]    height_limit_next;
  logic                  awaiting_value_next;
  logic [COUNT_W-1:0]    pending_count_next;
  logic [COL_CNT_W-1:0]  cur_column_next;
  logic [LINE_CNT_W-1:0] cur_line_next;

  // State as seen by the byte being taken; a file start restarts it.
  logic [1:0]            eff_phase;
  logic [HDR_CNT_W-1:0]  eff_count;
  logic [LIMIT_W-1:0]    eff_width;
  logic [LIMIT_W-1:0]    eff_height;
  logic                  eff_awaiting;
  logic [COUNT_W-1:0]    eff_pending;
  logic [COL_CNT_W-1:0]  eff_column;
  logic [LINE_CNT_W-1:0] eff_line;

  // Run that the byte being taken starts.
  logic                  f_produce;
  logic                  f_kind;
  logic [PIXEL_W-1:0]    f_value;
  logic [COL_CNT_W-1:0]  f_col;
  logic [LINE_CNT_W-1:0] f_line;
  logic [COUNT_W-1:0]    f_left;
  logic                  f_last;

  logic                  hdr_bad;
  logic                  run_go;
  logic [COUNT_W-1:0]    run_n;
  logic [COL_CNT_W-1:0]  next_col;
  logic                  past_edge;
  logic                  at_bottom;

  // Run register: the part of a run still to be emitted.
  logic                  run_kind;
  logic [PIXEL_W-1:0]    run_value;
  logic [COL_CNT_W-1:0]  run_col;
  logic [LINE_CNT_W-1:0] run_line;
  logic [COUNT_W-1:0]    run_left;
  logic                  run_last;

  // Head of the run: fresh from the input on a take, else from the run register.
  logic                  h_kind;
  logic [PIXEL_W-1:0]    h_value;
  logic [COL_CNT_W-1:0]  h_col;
  logic [LINE_CNT_W-1:0] h_line;
  logic [COUNT_W-1:0]    h_left;
  logic                  h_last;
  logic [LIMIT_W-1:0]    h_col_wide;
  logic [LIMIT_W-1:0]    h_line_wide;
  logic [COLUMN_W-1:0]   h_col_sat;

  // Output register.
  logic                  out_valid;
  logic                  out_kind;
  logic [PIXEL_W-1:0]    out_pixel;
  logic [COLUMN_W-1:0]   out_column;
  logic [LINE_W-1:0]     out_line;
  logic                  out_run_end;
  logic                  out_image_end;

  logic take;
  logic slot_free;

  assign take        = bytes.valid && cmd.ready;
  assign slot_free   = !out_valid || pixels.ready;
  assign bytes.ready = cmd.ready;

  always_comb begin
    if (bytes.file_start) begin
      eff_phase    = PH_HEADER;
      eff_count    = '0;
      eff_width    = '0;
      eff_height   = '0;
      eff_awaiting = 1'b0;
      eff_pending  = '0;
      eff_column   = '0;
      eff_line     = '0;
    end else begin
      eff_phase    = phase;
      eff_count    = header_count;
      eff_width    = width_limit;
      eff_height   = height_limit;
      eff_awaiting = awaiting_value;
      eff_pending  = pending_count;
      eff_column   = cur_column;
      eff_line     = cur_line;
    end
  end

  always_comb begin
    phase_next          = eff_phase;
    header_count_next   = eff_count;
    width_limit_next    = eff_width;
    height_limit_next   = eff_height;
    awaiting_value_next = eff_awaiting;
    pending_count_next  = eff_pending;
    cur_column_next     = eff_column;
    cur_line_next       = eff_line;

    f_produce = 1'b0;
    f_kind    = KIND_PIXEL;
    f_value   = bytes.data_byte;
    f_col     = eff_column;
    f_line    = eff_line;
    f_left    = COUNT_W'(1);
    f_last    = 1'b0;

    hdr_bad   = 1'b0;
    run_go    = 1'b0;
    run_n     = COUNT_W'(1);
    next_col  = eff_column;
    past_edge = 1'b0;
    at_bottom = 1'b0;

    case (eff_phase)
      PH_HEADER, PH_HEADER_BAD: begin
        case (eff_count)
          HDR_MANUFACTURER: hdr_bad = (bytes.data_byte != MANUFACTURER);
          HDR_VERSION:      hdr_bad = (bytes.data_byte != VERSION);
          HDR_ENCODING:     hdr_bad = (bytes.data_byte != ENCODING);
          HDR_BPP:          hdr_bad = (bytes.data_byte != PIXEL_DEPTH);
          HDR_XMAX_LO:      width_limit_next  = {eff_width[15:8], bytes.data_byte};
          HDR_XMAX_HI:      width_limit_next  = {bytes.data_byte, eff_width[7:0]};
          HDR_YMAX_LO:      height_limit_next = {eff_height[15:8], bytes.data_byte};
          HDR_YMAX_HI:      height_limit_next = {bytes.data_byte, eff_height[7:0]};
          default: begin
          end
        endcase
        if (hdr_bad) begin
          phase_next = PH_HEADER_BAD;
        end
        // Every check is judged together once ymax is complete.
        if (eff_count == HDR_YMAX_HI &&
            (phase_next == PH_HEADER_BAD ||
             width_limit_next >= LIMIT_W'(MAX_WIDTH) ||
             height_limit_next >= LIMIT_W'(MAX_HEIGHT))) begin
          phase_next = PH_IDLE;
          f_produce  = 1'b1;
          f_kind     = KIND_ERROR;
          f_value    = '0;
          f_col      = '0;
          f_line     = '0;
        end else begin
          header_count_next = eff_count + HDR_CNT_W'(1);
          if (eff_count == HDR_LAST) begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (eff_awaiting) begin
          run_n               = eff_pending;
          awaiting_value_next = 1'b0;
          run_go              = 1'b1;
        end else if (bytes.data_byte[7:6] == RUN_MARK) begin
          pending_count_next  = bytes.data_byte[COUNT_W-1:0];
          awaiting_value_next = 1'b1;
        end else begin
          run_go = 1'b1;
        end
        if (run_go && run_n != '0) begin
          next_col  = eff_column + COL_CNT_W'(run_n);
          past_edge = (LIMIT_W'(next_col) > eff_width);
          at_bottom = (LIMIT_W'(eff_line) == eff_height);
          f_produce = 1'b1;
          f_left    = run_n;
          f_last    = past_edge && at_bottom;
          if (past_edge) begin
            cur_column_next = '0;
            if (at_bottom) begin
              phase_next = PH_IDLE;
            end else begin
              cur_line_next = eff_line + LINE_CNT_W'(1);
            end
          end else begin
            cur_column_next = next_col;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (take) begin
      h_kind  = f_kind;
      h_value = f_value;
      h_col   = f_col;
      h_line  = f_line;
      h_left  = f_left;
      h_last  = f_last;
    end else begin
      h_kind  = run_kind;
      h_value = run_value;
      h_col   = run_col;
      h_line  = run_line;
      h_left  = run_left;
      h_last  = run_last;
    end
    h_col_wide  = LIMIT_W'(h_col);
    h_line_wide = LIMIT_W'(h_line);
    // A spilling run past the field saturates the reported column.
    if (h_col_wide > LIMIT_W'({COLUMN_W{1'b1}})) begin
      h_col_sat = {COLUMN_W{1'b1}};
    end else begin
      h_col_sat = h_col_wide[COLUMN_W-1:0];
    end
  end

  assign stat = '{take:      take,
                  produce:   f_produce,
                  multi:     (f_left != COUNT_W'(1)),
                  slot_free: slot_free,
                  run_last:  (run_left == COUNT_W'(1))};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      width_limit    <= '0;
      height_limit   <= '0;
      awaiting_value <= 1'b0;
      pending_count  <= '0;
      cur_column     <= '0;
      cur_line       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        width_limit    <= width_limit_next;
        height_limit   <= height_limit_next;
        awaiting_value <= awaiting_value_next;
        pending_count  <= pending_count_next;
        cur_column     <= cur_column_next;
        cur_line       <= cur_line_next;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take || cmd.emit) begin
      run_kind  <= h_kind;
      run_value <= h_value;
      run_line  <= h_line;
      run_last  <= h_last;
      if (cmd.emit) begin
        run_col  <= h_col + COL_CNT_W'(1);
        run_left <= h_left - COUNT_W'(1);
      end else begin
        run_col  <= h_col;
        run_left <= h_left;
      end
    end
    if (cmd.emit) begin
      out_kind      <= h_kind;
      out_pixel     <= h_value;
      out_column    <= h_col_sat;
      out_line      <= h_line_wide[LINE_W-1:0];
      out_run_end   <= (h_left == COUNT_W'(1));
      out_image_end <= (h_left == COUNT_W'(1)) && h_last;
    end
  end

  assign pixels.valid     = out_valid;
  assign pixels.kind      = out_kind;
  assign pixels.pixel     = out_pixel;
  assign pixels.column    = out_column;
  assign pixels.line      = out_line;
  assign pixels.run_end   = out_run_end;
  assign pixels.image_end = out_image_end;

  // The output register is never overwritten while a result still waits.
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slot_free)
    else $error("result loaded over a waiting result");

  // Once in the data phase the image limits have passed the header checks.
  a_limits_checked: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (width_limit < LIMIT_W'(MAX_WIDTH) &&
                            height_limit < LIMIT_W'(MAX_HEIGHT)))
    else $error("data phase entered with limits out of range");

  // Between bytes the column never rests beyond xmax.
  a_column_in_field: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (LIMIT_W'(cur_column) <= width_limit))
    else $error("column rests beyond xmax");

  // The line counter never passes ymax.
  a_line_in_field: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (LIMIT_W'(cur_line) <= height_limit))
    else $error("line counter beyond ymax");

endmodule

@@ design/pcx_rle_image_decoder.sv @@
// ----------------------------------------------------------------------------
// PCX run-length image decoder
// Checks the header of an 8-bit PCX file and decodes its pixel data.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the bytes channel, one per transaction, with
// file_start set on the first byte of each file. Results leave on the pixels
// channel: one pixel with its column and line, or a single error result
// (kind set) when the header is rejected at byte 11.
// Header bytes, but for a rejected byte 11, and run count bytes give no result.
// A literal byte's pixel is loaded into the output register once that
// register is free. A value byte with run count n gives n pixels, one per
// cycle while the receiver takes them, through the single output register;
// the input is not ready again until the last pixel of the run is registered.
// A count of zero gives no result.
// Reset clears the decoder to expect header byte 0 and empties the output
// register. When the receiver stalls, the output register holds its result
// and a run pauses; a byte that gives a result may still be taken while the
// previous result waits, its pixels then follow once the register frees.
// Bytes after the final pixel or after a rejected header give no result.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder
  import pcx_rle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pcx_byte_if.sink  bytes,
  pcx_pix_if.source pixels
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcx_rle_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pcx_rle_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .pixels (pixels),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
